[hw/rtl/trd_pkg.sv]
package trd_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_RLE_MODE        = 2'd0;
    localparam logic [1:0] CFG_BYTES_PER_PIXEL = 2'd1;
    localparam logic [1:0] CFG_PIXEL_TOTAL     = 2'd2;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 32;

    // reset values of the registers
    localparam logic [2:0]  BPP_RESET   = 3'd4;
    localparam logic [31:0] TOTAL_RESET = 32'd1;

    typedef enum logic [1:0] {
        FMT_16,
        FMT_24,
        FMT_32
    } t_pix_fmt;

    // one assembled pixel on its way from the front to the back
    typedef struct packed {
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
        logic [7:0] last;
        t_pix_fmt   fmt;
        logic [7:0] count;
        logic       done;
    } t_pix_rec;

endpackage

[hw/rtl/trd_front.sv]
module trd_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr,
    input  logic [trd_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [trd_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                           i_byte_acc,
    input  logic [7:0]                     i_data_byte,
    output logic                           o_rec_valid,
    output trd_pkg::t_pix_rec              o_rec
);
    import trd_pkg::*;

    logic        r_rle_mode, n_rle_mode;
    logic [2:0]  r_bpp, n_bpp;
    logic [31:0] r_pixel_total, n_pixel_total;
    logic [1:0]  r_byte_pos, n_byte_pos;
    logic [7:0]  r_held [3];
    logic        r_expect_header, n_expect_header;
    logic        r_packet_is_run, n_packet_is_run;
    logic [7:0]  r_packet_left, n_packet_left;
    logic [31:0] r_pixels_left, n_pixels_left;

    t_pix_fmt    fmt;
    logic [1:0]  last_pos;
    logic        live;
    logic        is_header;
    logic        is_partial;
    logic [7:0]  run_cnt;
    logic [7:0]  clamp_cnt;
    logic        restart;

    always_comb begin
        if (r_bpp inside {[3'd0:3'd2]}) begin
            fmt      = FMT_16;
            last_pos = 2'd1;
        end else if (r_bpp == 3'd3) begin
            fmt      = FMT_24;
            last_pos = 2'd2;
        end else begin
            fmt      = FMT_32;
            last_pos = 2'd3;
        end
    end

    assign live       = i_byte_acc && (r_pixels_left != 32'd0);
    assign is_header  = r_rle_mode && r_expect_header;
    assign is_partial = r_byte_pos < last_pos;

    // run packets cover the whole packet in one item
    always_comb begin
        if (r_rle_mode && r_packet_is_run) begin
            run_cnt = (r_packet_left == 8'd0) ? 8'd1 : r_packet_left;
        end else begin
            run_cnt = 8'd1;
        end
        if ({24'd0, run_cnt} > r_pixels_left) begin
            clamp_cnt = r_pixels_left[7:0];
        end else begin
            clamp_cnt = run_cnt;
        end
    end

    always_comb begin
        n_rle_mode      = r_rle_mode;
        n_bpp           = r_bpp;
        n_pixel_total   = r_pixel_total;
        n_byte_pos      = r_byte_pos;
        n_expect_header = r_expect_header;
        n_packet_is_run = r_packet_is_run;
        n_packet_left   = r_packet_left;
        n_pixels_left   = r_pixels_left;
        o_rec_valid     = 1'b0;
        restart         = 1'b0;

        if (i_cfg_wr) begin
            case (i_cfg_index)
                CFG_RLE_MODE: begin
                    n_rle_mode = i_cfg_data[0];
                    restart    = 1'b1;
                end
                CFG_BYTES_PER_PIXEL: begin
                    n_bpp   = i_cfg_data[2:0];
                    restart = 1'b1;
                end
                CFG_PIXEL_TOTAL: begin
                    n_pixel_total = i_cfg_data;
                    restart       = 1'b1;
                end
                default: ;
            endcase
            if (restart) begin
                n_byte_pos      = 2'd0;
                n_expect_header = 1'b1;
                n_packet_is_run = 1'b0;
                n_packet_left   = 8'd0;
                n_pixels_left   = n_pixel_total;
            end
        end else if (live) begin
            if (is_header) begin
                n_packet_is_run = i_data_byte[7];
                n_packet_left   = {1'b0, i_data_byte[6:0]} + 8'd1;
                n_expect_header = 1'b0;
                n_byte_pos      = 2'd0;
            end else if (is_partial) begin
                n_byte_pos = r_byte_pos + 2'd1;
            end else begin
                n_byte_pos  = 2'd0;
                o_rec_valid = 1'b1;
                if (r_rle_mode) begin
                    if (r_packet_is_run) begin
                        n_packet_left = 8'd0;
                    end else if (r_packet_left != 8'd0) begin
                        n_packet_left = r_packet_left - 8'd1;
                    end
                    if (n_packet_left == 8'd0) begin
                        n_expect_header = 1'b1;
                    end
                end
                n_pixels_left = r_pixels_left - {24'd0, clamp_cnt};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rle_mode      <= 1'b0;
            r_bpp           <= BPP_RESET;
            r_pixel_total   <= TOTAL_RESET;
            r_byte_pos      <= 2'd0;
            r_expect_header <= 1'b1;
            r_packet_is_run <= 1'b0;
            r_packet_left   <= 8'd0;
            r_pixels_left   <= TOTAL_RESET;
        end else begin
            r_rle_mode      <= n_rle_mode;
            r_bpp           <= n_bpp;
            r_pixel_total   <= n_pixel_total;
            r_byte_pos      <= n_byte_pos;
            r_expect_header <= n_expect_header;
            r_packet_is_run <= n_packet_is_run;
            r_packet_left   <= n_packet_left;
            r_pixels_left   <= n_pixels_left;
        end
    end

    // held bytes of the pixel being assembled
    always_ff @(posedge i_clk) begin
        if (!i_cfg_wr && live && !is_header && is_partial) begin
            r_held[r_byte_pos] <= i_data_byte;
        end
    end

    always_comb begin
        o_rec.byte0 = r_held[0];
        o_rec.byte1 = r_held[1];
        o_rec.byte2 = r_held[2];
        o_rec.last  = i_data_byte;
        o_rec.fmt   = fmt;
        o_rec.count = clamp_cnt;
        o_rec.done  = (r_pixels_left == {24'd0, clamp_cnt});
    end

endmodule

[hw/rtl/trd_queue.sv]
module trd_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  trd_pkg::t_pix_rec i_rec,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_empty,
    output trd_pkg::t_pix_rec o_rec
);
    import trd_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_pix_rec         r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_rec   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

endmodule

[hw/rtl/trd_back.sv]
module trd_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rec_valid,
    input  trd_pkg::t_pix_rec i_rec,
    output logic              o_rec_pop,
    input  logic              i_pop,
    output logic              o_empty,
    output logic [7:0]        o_red,
    output logic [7:0]        o_green,
    output logic [7:0]        o_blue,
    output logic [7:0]        o_alpha,
    output logic [7:0]        o_repeat_count,
    output logic              o_image_done
);
    import trd_pkg::*;

    logic       r_valid, n_valid;
    logic [7:0] r_red, r_green, r_blue, r_alpha, r_count;
    logic       r_done;
    logic [7:0] n_red, n_green, n_blue, n_alpha;

    // the output register takes a new item when it is free or being drained
    assign o_rec_pop = i_rec_valid && (!r_valid || i_pop);

    always_comb begin
        case (i_rec.fmt)
            FMT_16: begin
                n_red   = {i_rec.last[6:2], 3'b000};
                n_green = {i_rec.last[1:0], i_rec.byte0[7:5], 3'b000};
                n_blue  = {i_rec.byte0[4:0], 3'b000};
                n_alpha = {i_rec.last[7], 7'd0};
            end
            FMT_24: begin
                n_red   = i_rec.last;
                n_green = i_rec.byte1;
                n_blue  = i_rec.byte0;
                n_alpha = 8'd0;
            end
            default: begin
                n_red   = i_rec.byte2;
                n_green = i_rec.byte1;
                n_blue  = i_rec.byte0;
                n_alpha = i_rec.last;
            end
        endcase
    end

    always_comb begin
        n_valid = r_valid;
        if (o_rec_pop) begin
            n_valid = 1'b1;
        end else if (i_pop) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rec_pop) begin
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
            r_alpha <= n_alpha;
            r_count <= i_rec.count;
            r_done  <= i_rec.done;
        end
    end

    assign o_empty        = !r_valid;
    assign o_red          = r_red;
    assign o_green        = r_green;
    assign o_blue         = r_blue;
    assign o_alpha        = r_alpha;
    assign o_repeat_count = r_count;
    assign o_image_done   = r_done;

endmodule

[hw/rtl/tga_pixel_rle_decoder_top.sv]
// TGA pixel-data decoder for uncompressed (type 2) and run-length (type 10)
// images. Push the bytes of the pixel-data section one at a time; pop decoded
// pixels as red, green, blue and alpha bytes with a repeat count (a run packet
// gives one item covering the whole run, cut at the end of the image, every
// other pixel gives an item with count 1) and an image_done flag on the item
// that completes the image. One byte is taken every clock while full is low:
// the front assembles pixels and tracks packets and the pixel count, and an
// item then passes a QUEUE_DEPTH-entry queue and the output register of the
// expansion stage. full rises only when the queue is full, which happens only
// while the result side is not popping. Header bytes and bytes after the image
// is complete give no item. Configuration writes are always ready (o_cfg_ready
// is tied high) and writes to registers 0 to 2 restart decoding; write them
// only while the block is idle. Register 0 is rle_mode, 1 is bytes_per_pixel
// (0 or 1 read as 2, 5 to 7 as 4), 2 is pixel_total.
module tga_pixel_rle_decoder_top #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // byte input
    input  logic                            push,
    output logic                            full,
    input  logic [7:0]                      i_data_byte,
    // pixel output
    output logic                            empty,
    input  logic                            pop,
    output logic [7:0]                      o_red,
    output logic [7:0]                      o_green,
    output logic [7:0]                      o_blue,
    output logic [7:0]                      o_alpha,
    output logic [7:0]                      o_repeat_count,
    output logic                            o_image_done,
    // configuration writes
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [trd_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [trd_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import trd_pkg::*;

    logic     byte_acc;
    logic     cfg_wr;
    logic     front_valid;
    t_pix_rec front_rec;
    logic     q_full;
    logic     q_empty;
    t_pix_rec q_rec;
    logic     back_pop;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid;

    // a byte is taken whenever the queue has room for what it might produce
    assign full     = q_full;
    assign byte_acc = push && !q_full;

    // front: packet headers, pixel assembly, count clamping
    trd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr    (cfg_wr),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_byte_acc  (byte_acc),
        .i_data_byte (i_data_byte),
        .o_rec_valid (front_valid),
        .o_rec       (front_rec)
    );

    // short queue so the byte side and the pixel side stall on their own
    trd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_rec   (front_rec),
        .o_full  (q_full),
        .i_pop   (back_pop),
        .o_empty (q_empty),
        .o_rec   (q_rec)
    );

    // back: colour expansion into the output register
    trd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_rec_valid    (!q_empty),
        .i_rec          (q_rec),
        .o_rec_pop      (back_pop),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_red          (o_red),
        .o_green        (o_green),
        .o_blue         (o_blue),
        .o_alpha        (o_alpha),
        .o_repeat_count (o_repeat_count),
        .o_image_done   (o_image_done)
    );

endmodule

[hw/rtl/trd_checker.sv]
module trd_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            full,
    input logic                            empty,
    input logic                            pop,
    input logic [7:0]                      o_red,
    input logic [7:0]                      o_green,
    input logic [7:0]                      o_blue,
    input logic [7:0]                      o_alpha,
    input logic [7:0]                      o_repeat_count,
    input logic                            o_image_done
);

    // nothing waits and nothing blocks straight after reset
    a_reset_clears : assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
    else $error("outputs not idle after reset");

    // a waiting item holds until popped
    a_result_holds : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_red) && $stable(o_green)
            && $stable(o_blue) && $stable(o_alpha) && $stable(o_repeat_count)
            && $stable(o_image_done)))
    else $error("waiting item changed before pop");

    // every item covers at least one pixel and at most one run packet
    a_count_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_repeat_count != 8'd0 && o_repeat_count <= 8'd128))
    else $error("repeat count out of range");

    // full only builds up while the pixel side is not draining
    a_full_needs_stall : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(full) |-> $past(!empty && !pop))
    else $error("full raised while results were drained");

endmodule

bind tga_pixel_rle_decoder_top trd_checker u_trd_checker (.*);
